@@ sv/ssma_pkg.sv @@
// Shared types and constants for the sensor scan with moving average block.
// No dependencies; used by every module of the block but ssma_hist_ram, by scoped names.
package ssma_pkg;

    localparam int TIME_W   = 16;
    localparam int SAMPLE_W = 10;
    localparam int LED_W    = 12;
    localparam int SUM_W    = 16;
    localparam int CFG_W    = 16;

    // start channel codes
    localparam logic [1:0] CH_NONE    = 2'd0;
    localparam logic [1:0] CH_BATTERY = 2'd1;
    localparam logic [1:0] CH_LIGHT   = 2'd2;

    // configuration register indexes
    localparam logic CFG_THRESHOLD = 1'b0;
    localparam logic CFG_INTERVAL  = 1'b1;

    localparam logic [LED_W-1:0]    LED_IDLE_VALUE  = 12'hFFF;
    localparam logic [SAMPLE_W-1:0] BAT_AVG_RESET   = 10'd150;
    localparam logic [SAMPLE_W-1:0] LIGHT_AVG_RESET = 10'd600;
    localparam logic [TIME_W-1:0]   INTERVAL_RESET  = 16'd500;

    typedef struct packed {
        logic [TIME_W-1:0]   now_ms;
        logic [SAMPLE_W-1:0] conversion_sample;
        logic [SAMPLE_W-1:0] led_sample;
    } in_word_t;

    typedef struct packed {
        logic [LED_W-1:0]    led_value;
        logic [1:0]          start_channel;
        logic [SAMPLE_W-1:0] battery_average;
        logic [SAMPLE_W-1:0] light_average;
        logic                power_down;
        logic                target_update;
    } out_word_t;

    // per-tick command from the scan sequencer to the history pipeline
    typedef struct packed {
        logic                push;
        logic                is_light;
        logic [SAMPLE_W-1:0] sample;
        logic [LED_W-1:0]    led_value;
        logic [1:0]          start_channel;
    } scan_cmd_t;

endpackage

@@ sv/ssma_hist_ram.sv @@
// History memory for both channels, with a registered read.
// Per-entry valid bits make never-written entries read as zero after reset.
// Depends on nothing outside this file.
module ssma_hist_ram #(
    parameter int AW = 6,
    parameter int DW = 10
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output logic [DW-1:0] rd_data,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [DW-1:0] wr_data
);

    localparam int DEPTH = 1 << AW;

    logic [DW-1:0]    mem [DEPTH];
    logic [DEPTH-1:0] valid_reg;
    logic [DW-1:0]    rd_data_reg;
    logic             rd_valid_reg;

    // storage array and registered read
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // valid bits cleared at reset, read alongside the data
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end else begin
            if (wr_en) begin
                valid_reg[wr_addr] <= 1'b1;
            end
            if (rd_en) begin
                rd_valid_reg <= valid_reg[rd_addr];
            end
        end
    end

    assign rd_data = rd_valid_reg ? rd_data_reg : '0;

endmodule

@@ sv/ssma_scan_ctrl.sv @@
// Conversion scan sequencer: pending flags, interval timer, write indexes.
// Depends on ssma_pkg for the input word and command types.
module ssma_scan_ctrl #(
    parameter int HISTORY_DEPTH = 32,
    parameter int IDX_W = 5
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       accept,
    input  ssma_pkg::in_word_t         in_word,
    input  logic [ssma_pkg::TIME_W-1:0] interval,
    output ssma_pkg::scan_cmd_t        cmd,
    output logic [IDX_W-1:0]           push_idx
);

    logic                        pending_reg, pending_next;
    logic                        is_light_reg, is_light_next;
    logic                        first_reg, first_next;
    logic [ssma_pkg::TIME_W-1:0] last_reg, last_next;
    logic [IDX_W-1:0]            bat_idx_reg, bat_idx_next;
    logic [IDX_W-1:0]            light_idx_reg, light_idx_next;
    logic [ssma_pkg::TIME_W-1:0] elapsed;
    logic [IDX_W-1:0]            idx_inc;

    // pick the write slot of the channel that was started
    assign push_idx = is_light_reg ? light_idx_reg : bat_idx_reg;
    assign idx_inc  = (push_idx == IDX_W'(HISTORY_DEPTH - 1)) ? '0 : push_idx + 1'b1;

    // tick decode: take the pending result, then check the interval
    always_comb begin
        pending_next   = pending_reg;
        is_light_next  = is_light_reg;
        first_next     = first_reg;
        last_next      = last_reg;
        bat_idx_next   = bat_idx_reg;
        light_idx_next = light_idx_reg;

        cmd.push          = pending_reg;
        cmd.is_light      = is_light_reg;
        cmd.sample        = in_word.conversion_sample;
        cmd.led_value     = first_reg ? ssma_pkg::LED_IDLE_VALUE
                                      : {2'b00, in_word.led_sample};
        cmd.start_channel = ssma_pkg::CH_NONE;

        if (pending_reg) begin
            last_next    = in_word.now_ms;
            pending_next = 1'b0;
            if (is_light_reg) begin
                light_idx_next = idx_inc;
            end else begin
                bat_idx_next = idx_inc;
            end
        end

        elapsed = in_word.now_ms - last_next;
        if (elapsed > interval) begin
            if (!first_reg && !is_light_reg) begin
                cmd.start_channel = ssma_pkg::CH_LIGHT;
                is_light_next     = 1'b1;
            end else begin
                cmd.start_channel = ssma_pkg::CH_BATTERY;
                is_light_next     = 1'b0;
                first_next        = 1'b0;
            end
            pending_next = 1'b1;
        end
    end

    // sequencer state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pending_reg   <= 1'b0;
            is_light_reg  <= 1'b0;
            first_reg     <= 1'b1;
            last_reg      <= '0;
            bat_idx_reg   <= '0;
            light_idx_reg <= '0;
        end else if (accept) begin
            pending_reg   <= pending_next;
            is_light_reg  <= is_light_next;
            first_reg     <= first_next;
            last_reg      <= last_next;
            bat_idx_reg   <= bat_idx_next;
            light_idx_reg <= light_idx_next;
        end
    end

endmodule

@@ sv/sensor_scan_with_moving_average_core.sv @@
// Top level of the sensor scan with moving average block.
// Depends on ssma_pkg, ssma_scan_ctrl and ssma_hist_ram.
//
// Usage:
//   s_valid/s_ready/s_data carry one timer tick per word (time, pending
//   conversion result, LED sample). m_valid/m_ready/m_data return one result
//   word per tick: LED value, conversion start request, both averages and the
//   power-down and target-update flags.
//   cfg_wr_en/cfg_index/cfg_wdata write the threshold (index 0) and the
//   conversion interval (index 1); write them only while the block is idle.
// Pipeline and throughput:
//   a tick accepted into the block passes the history read, the sum update
//   and write-back, then averaging (one 16x18 reciprocal multiply) into the
//   output register. One word per cycle is sustained while the output is
//   not stalled; the history memory is read and written once per pushed tick.
// Reset and stall:
//   synchronous reset clears the sequencer, the valid bits of the history
//   memory (entries read as zero until written), the sums, and loads the
//   averages with 150 and 600. While m_valid is high and m_ready is low the
//   whole pipeline holds and s_ready is low.
module sensor_scan_with_moving_average_core #(
    parameter int HISTORY_DEPTH = 32
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  ssma_pkg::in_word_t            s_data,
    output logic                          m_valid,
    input  logic                          m_ready,
    output ssma_pkg::out_word_t           m_data,
    input  logic                          cfg_wr_en,
    input  logic                          cfg_index,
    input  logic [ssma_pkg::CFG_W-1:0]    cfg_wdata
);

    localparam int IDX_W  = $clog2(HISTORY_DEPTH);
    localparam int AW     = IDX_W + 1;
    // exact division by the depth through a rounded-up reciprocal
    localparam int DIV_SH = ssma_pkg::SUM_W + IDX_W;
    localparam int DIV_M  = ((1 << DIV_SH) + HISTORY_DEPTH - 1) / HISTORY_DEPTH;
    localparam int MUL_W  = ssma_pkg::SUM_W + 2;
    localparam int PROD_W = ssma_pkg::SUM_W + MUL_W;

    localparam int SW = ssma_pkg::SAMPLE_W;

    logic                         adv;
    logic                         accept;
    ssma_pkg::scan_cmd_t          cmd;
    logic [IDX_W-1:0]             push_idx;

    logic [SW-1:0]                thr_reg;
    logic [ssma_pkg::TIME_W-1:0]  interval_reg;

    logic                         s1_valid_reg;
    ssma_pkg::scan_cmd_t          s1_cmd_reg;
    logic [IDX_W-1:0]             s1_idx_reg;
    logic                         s2_valid_reg;
    ssma_pkg::scan_cmd_t          s2_cmd_reg;

    logic [SW-1:0]                old_entry;
    logic                         wr_en;
    logic [ssma_pkg::SUM_W-1:0]   bat_sum_reg, light_sum_reg;
    logic [ssma_pkg::SUM_W-1:0]   s1_sum, sum_next;
    logic [ssma_pkg::SUM_W-1:0]   s2_sum;
    logic [PROD_W-1:0]            prod;
    logic [SW-1:0]                new_avg;
    logic [SW-1:0]                bat_avg_reg, bat_avg_next;
    logic [SW-1:0]                light_avg_reg, light_avg_next;

    logic                         m_valid_reg;
    ssma_pkg::out_word_t          m_data_reg, m_data_next;

    // pipeline moves as a whole when the output slot is free or taken
    assign adv     = !m_valid_reg || m_ready;
    assign s_ready = adv;
    assign accept  = s_valid && adv;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thr_reg      <= '0;
            interval_reg <= ssma_pkg::INTERVAL_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                ssma_pkg::CFG_THRESHOLD: thr_reg      <= cfg_wdata[SW-1:0];
                ssma_pkg::CFG_INTERVAL:  interval_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    ssma_scan_ctrl #(
        .HISTORY_DEPTH (HISTORY_DEPTH),
        .IDX_W         (IDX_W)
    ) u_scan_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .accept   (accept),
        .in_word  (s_data),
        .interval (interval_reg),
        .cmd      (cmd),
        .push_idx (push_idx)
    );

    ssma_hist_ram #(
        .AW (AW),
        .DW (SW)
    ) u_hist_ram (
        .aclk    (aclk),
        .aresetn (aresetn),
        .rd_en   (accept && cmd.push),
        .rd_addr ({cmd.is_light, push_idx}),
        .rd_data (old_entry),
        .wr_en   (wr_en),
        .wr_addr ({s1_cmd_reg.is_light, s1_idx_reg}),
        .wr_data (s1_cmd_reg.sample)
    );

    // stage 1: replace the oldest entry and update the running sum
    assign wr_en    = adv && s1_valid_reg && s1_cmd_reg.push;
    assign s1_sum   = s1_cmd_reg.is_light ? light_sum_reg : bat_sum_reg;
    assign sum_next = s1_sum - ssma_pkg::SUM_W'(old_entry)
                      + ssma_pkg::SUM_W'(s1_cmd_reg.sample);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bat_sum_reg   <= '0;
            light_sum_reg <= '0;
        end else if (wr_en) begin
            if (s1_cmd_reg.is_light) begin
                light_sum_reg <= sum_next;
            end else begin
                bat_sum_reg <= sum_next;
            end
        end
    end

    // stage 2: average by reciprocal multiply, flags, output word
    assign s2_sum  = s2_cmd_reg.is_light ? light_sum_reg : bat_sum_reg;
    assign prod    = PROD_W'(s2_sum) * PROD_W'(MUL_W'(DIV_M));
    assign new_avg = prod[DIV_SH +: SW];

    always_comb begin
        bat_avg_next   = bat_avg_reg;
        light_avg_next = light_avg_reg;
        m_data_next.power_down    = 1'b0;
        m_data_next.target_update = 1'b0;
        if (s2_cmd_reg.push) begin
            if (s2_cmd_reg.is_light) begin
                light_avg_next = new_avg;
            end else begin
                bat_avg_next              = new_avg;
                m_data_next.power_down    = new_avg > thr_reg;
                m_data_next.target_update = 1'b1;
            end
        end
        m_data_next.led_value       = s2_cmd_reg.led_value;
        m_data_next.start_channel   = s2_cmd_reg.start_channel;
        m_data_next.battery_average = bat_avg_next;
        m_data_next.light_average   = light_avg_next;
    end

    // pipeline valid bits and averages
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            m_valid_reg   <= 1'b0;
            bat_avg_reg   <= ssma_pkg::BAT_AVG_RESET;
            light_avg_reg <= ssma_pkg::LIGHT_AVG_RESET;
        end else if (adv) begin
            s1_valid_reg <= s_valid;
            s2_valid_reg <= s1_valid_reg;
            m_valid_reg  <= s2_valid_reg;
            if (s2_valid_reg) begin
                bat_avg_reg   <= bat_avg_next;
                light_avg_reg <= light_avg_next;
            end
        end
    end

    // pipeline payload
    always_ff @(posedge aclk) begin
        if (adv) begin
            s1_cmd_reg <= cmd;
            s1_idx_reg <= push_idx;
            s2_cmd_reg <= s1_cmd_reg;
            m_data_reg <= m_data_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

@@ sv/ssma_checker.sv @@
// Port-level checks for the sensor scan with moving average block.
// Depends on ssma_pkg; attached to the top level by the bind below.
module ssma_checker (
    input logic                aclk,
    input logic                aresetn,
    input logic                m_valid,
    input logic                m_ready,
    input ssma_pkg::out_word_t m_data
);

    // a stalled result word holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result word changed while stalled");

    // a tick that takes a battery conversion result never starts another
    a_no_start_on_update: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.target_update |-> m_data.start_channel == ssma_pkg::CH_NONE)
        else $error("conversion started on an update tick");

    // power-down only comes with a battery update
    a_pd_with_update: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.power_down |-> m_data.target_update)
        else $error("power-down without battery update");

    // a light start follows the first battery start, so the led value is live
    a_light_after_battery: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.start_channel == ssma_pkg::CH_LIGHT
            |-> m_data.led_value[11:10] == 2'b00)
        else $error("light start before first battery start");

    // start code stays in range
    a_start_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_data.start_channel != 2'd3)
        else $error("illegal start channel code");

endmodule

bind sensor_scan_with_moving_average_core ssma_checker u_ssma_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);
